### rtl/disk_block_bitmap_allocator_assert.svh
// ----------------------------------------------------------------------------
// Disk block bitmap allocator assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef DISK_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define DISK_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DBBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBBA_ASSERT_NOW(lbl, ante, cons, msg)
`define DBBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/dbba_pkg.sv
// ----------------------------------------------------------------------------
// Disk block bitmap allocator package
// Request codes, result status codes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbba_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED     = 3'd0;
  localparam logic [2:0] ST_FREED         = 3'd1;
  localparam logic [2:0] ST_FULL          = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
  localparam logic [2:0] ST_BAD_ADDRESS   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_REJECT
  } state_e;

endpackage

`default_nettype wire

### rtl/disk_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Disk block bitmap allocator
// First-fit allocator over a per-cylinder free-space bitmap held in a memory.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid_i, in_stall_o) and each one
// produces exactly one result transfer on the output channel (out_valid_o,
// out_stall_i). An allocate request scans the bitmap one cylinder row per
// cycle through the single memory read port. A free request does one
// read-modify-write of its row, and an out-of-range address is answered
// as well. The block handles one request at a time and takes the next one
// the cycle after a result is registered. Results sit in an output
// register; a new request is taken while an earlier result still waits
// there, and the controller holds a finished result, without updating the
// bitmap, until that register is free. Reset marks every row as never
// written through one valid flip-flop per cylinder, so all blocks read as
// free at once and no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "disk_block_bitmap_allocator_assert.svh"

module disk_block_bitmap_allocator #(
  parameter int unsigned NUM_CYLINDERS       = 8,
  parameter int unsigned BLOCKS_PER_CYLINDER = 8,
  parameter int unsigned RECORDS_PER_TRACK   = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       func_i,
  input  wire logic [2:0] req_cylinder_i,
  input  wire logic       req_track_i,
  input  wire logic [1:0] req_record_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [2:0]      got_cylinder_o,
  output logic            got_track_o,
  output logic [1:0]      got_record_o
);

  localparam int unsigned RW = (NUM_CYLINDERS > 1) ? $clog2(NUM_CYLINDERS) : 1;
  localparam int unsigned BW = (BLOCKS_PER_CYLINDER > 1) ? $clog2(BLOCKS_PER_CYLINDER) : 1;
  localparam int unsigned IW = 7;
  localparam logic [RW-1:0] LAST_ROW = RW'(NUM_CYLINDERS - 1);

  logic [BLOCKS_PER_CYLINDER-1:0] mem [NUM_CYLINDERS];
  logic [NUM_CYLINDERS-1:0]       vld_q;
  logic [BLOCKS_PER_CYLINDER-1:0] rdata_q;
  logic                           rd_vld_q;

  dbba_pkg::state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW-1:0] cyl_q, cyl_d;
  logic [BW-1:0] bit_q, bit_d;

  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q;
  logic [2:0] got_cyl_q;
  logic       got_trk_q;
  logic [1:0] got_rec_q;

  logic                           accept;
  logic                           can_post;
  logic                           post;
  logic                           mem_re;
  logic [RW-1:0]                  raddr;
  logic                           mem_we;
  logic [RW-1:0]                  waddr;
  logic [BLOCKS_PER_CYLINDER-1:0] wdata;
  logic [BLOCKS_PER_CYLINDER-1:0] eff_row;
  logic                           fz_found;
  logic [BW-1:0]                  fz_idx;
  logic [IW-1:0]                  req_idx;
  logic                           req_bad;
  logic [2:0]                     res_status;
  logic [2:0]                     res_cyl;
  logic                           res_trk;
  logic [1:0]                     res_rec;
  logic                           trk_tab [BLOCKS_PER_CYLINDER];
  logic [1:0]                     rec_tab [BLOCKS_PER_CYLINDER];

  for (genvar g = 0; g < BLOCKS_PER_CYLINDER; g++) begin : g_addr_tab
    localparam int unsigned TrkVal = g / RECORDS_PER_TRACK;
    localparam int unsigned RecVal = g % RECORDS_PER_TRACK;
    assign trk_tab[g] = 1'(TrkVal);
    assign rec_tab[g] = 2'(RecVal);
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign can_post = !out_valid_q || !out_stall_i;
  assign eff_row  = rd_vld_q ? rdata_q : '0;

  assign req_idx = (req_track_i ? IW'(RECORDS_PER_TRACK) : '0) + IW'(req_record_i);
  assign req_bad = (32'(req_cylinder_i) >= NUM_CYLINDERS)
                || (32'(req_record_i) >= RECORDS_PER_TRACK)
                || (32'(req_idx) >= BLOCKS_PER_CYLINDER);

  always_comb begin
    fz_found = 1'b0;
    fz_idx   = '0;
    for (int i = BLOCKS_PER_CYLINDER - 1; i >= 0; i--) begin
      if (!eff_row[i]) begin
        fz_found = 1'b1;
        fz_idx   = BW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbba_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == dbba_pkg::FUNC_ALLOC) begin
            state_d = dbba_pkg::S_SCAN;
          end else if (req_bad) begin
            state_d = dbba_pkg::S_REJECT;
          end else begin
            state_d = dbba_pkg::S_CHECK;
          end
        end
      end
      dbba_pkg::S_SCAN: begin
        if ((fz_found || row_q == LAST_ROW) && can_post) begin
          state_d = dbba_pkg::S_IDLE;
        end
      end
      dbba_pkg::S_CHECK, dbba_pkg::S_REJECT: begin
        if (can_post) begin
          state_d = dbba_pkg::S_IDLE;
        end
      end
      default: state_d = dbba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != dbba_pkg::S_IDLE);
    mem_re     = 1'b0;
    raddr      = '0;
    mem_we     = 1'b0;
    waddr      = row_q;
    wdata      = eff_row;
    row_d      = row_q;
    cyl_d      = cyl_q;
    bit_d      = bit_q;
    post       = 1'b0;
    res_status = dbba_pkg::ST_FULL;
    res_cyl    = '0;
    res_trk    = 1'b0;
    res_rec    = '0;
    case (state_q)
      dbba_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == dbba_pkg::FUNC_ALLOC) begin
            mem_re = 1'b1;
            raddr  = '0;
            row_d  = '0;
          end else if (!req_bad) begin
            mem_re = 1'b1;
            raddr  = RW'(req_cylinder_i);
            cyl_d  = RW'(req_cylinder_i);
            bit_d  = BW'(req_idx);
          end
        end
      end
      dbba_pkg::S_SCAN: begin
        if (fz_found) begin
          if (can_post) begin
            post       = 1'b1;
            mem_we     = 1'b1;
            waddr      = row_q;
            wdata      = eff_row | (BLOCKS_PER_CYLINDER'(1) << fz_idx);
            res_status = dbba_pkg::ST_ALLOCATED;
            res_cyl    = 3'(row_q);
            res_trk    = trk_tab[fz_idx];
            res_rec    = rec_tab[fz_idx];
          end
        end else if (row_q == LAST_ROW) begin
          if (can_post) begin
            post       = 1'b1;
            res_status = dbba_pkg::ST_FULL;
          end
        end else begin
          mem_re = 1'b1;
          raddr  = row_q + RW'(1);
          row_d  = row_q + RW'(1);
        end
      end
      dbba_pkg::S_CHECK: begin
        if (can_post) begin
          post = 1'b1;
          if (eff_row[bit_q]) begin
            mem_we     = 1'b1;
            waddr      = cyl_q;
            wdata      = eff_row & ~(BLOCKS_PER_CYLINDER'(1) << bit_q);
            res_status = dbba_pkg::ST_FREED;
          end else begin
            res_status = dbba_pkg::ST_NOT_ALLOCATED;
          end
        end
      end
      dbba_pkg::S_REJECT: begin
        if (can_post) begin
          post       = 1'b1;
          res_status = dbba_pkg::ST_BAD_ADDRESS;
        end
      end
      default: begin
        post = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (post) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q  <= mem[raddr];
      rd_vld_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      state_q     <= dbba_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    cyl_q <= cyl_d;
    bit_q <= bit_d;
    if (post) begin
      status_q  <= res_status;
      got_cyl_q <= res_cyl;
      got_trk_q <= res_trk;
      got_rec_q <= res_rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign got_cylinder_o = got_cyl_q;
  assign got_track_o    = got_trk_q;
  assign got_record_o   = got_rec_q;

  `DBBA_ASSERT_NOW(a_write_with_result, mem_we, post && can_post,
                   "bitmap written without a result")
  `DBBA_ASSERT_NEXT(a_post_returns_idle, post, state_q == dbba_pkg::S_IDLE,
                    "controller did not return to idle")
  `DBBA_ASSERT_NOW(a_scan_row_range, state_q == dbba_pkg::S_SCAN, row_q <= LAST_ROW,
                   "scan row beyond last cylinder")
  `DBBA_ASSERT_NOW(a_no_address_on_fail,
                   out_valid_o && status_o != dbba_pkg::ST_ALLOCATED,
                   got_cylinder_o == 3'd0 && !got_track_o && got_record_o == 2'd0,
                   "address fields set without an allocation")

endmodule

`default_nettype wire

### test/tb_disk_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Disk block bitmap allocator testbench
// Drives allocate and free requests with random idling on both channels and
// checks every result against a first-fit bitmap kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_disk_block_bitmap_allocator;

  localparam int NUM_CYL     = 8;
  localparam int BLK_PER_CYL = 8;
  localparam int REC_PER_TRK = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 2 * NUM_CYL + 8;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] cyl;
    logic       trk;
    logic [1:0] rec;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic       func = dbba_pkg::FUNC_ALLOC;
  logic [2:0] req_cyl = '0;
  logic       req_trk = 1'b0;
  logic [1:0] req_rec = '0;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [2:0] status_o;
  logic [2:0] got_cyl_o;
  logic       got_trk_o;
  logic [1:0] got_rec_o;

  logic [BLK_PER_CYL-1:0] used_rows [NUM_CYL];
  outcome_t pending_outcomes [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int request_count = 0;
  int cycle_count = 0;
  int status_seen [5];

  disk_block_bitmap_allocator #(
    .NUM_CYLINDERS      (NUM_CYL),
    .BLOCKS_PER_CYLINDER(BLK_PER_CYL),
    .RECORDS_PER_TRACK  (REC_PER_TRK)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .func_i        (func),
    .req_cylinder_i(req_cyl),
    .req_track_i   (req_trk),
    .req_record_i  (req_rec),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .got_cylinder_o(got_cyl_o),
    .got_track_o   (got_trk_o),
    .got_record_o  (got_rec_o)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // First-fit bitmap update for one request and the result it must produce.
  function automatic outcome_t predict_outcome(logic f, logic [2:0] cyl, logic trk,
                                               logic [1:0] rec);
    outcome_t res;
    int idx;
    bit found;
    res = '0;
    found = 1'b0;
    idx = int'(trk) * REC_PER_TRK + int'(rec);
    if (f == dbba_pkg::FUNC_ALLOC) begin
      res.status = dbba_pkg::ST_FULL;
      for (int c = 0; c < NUM_CYL; c++) begin
        for (int b = 0; b < BLK_PER_CYL; b++) begin
          if (!found && !used_rows[c][b]) begin
            found = 1'b1;
            used_rows[c][b] = 1'b1;
            res.status = dbba_pkg::ST_ALLOCATED;
            res.cyl = 3'(c);
            res.trk = 1'(b / REC_PER_TRK);
            res.rec = 2'(b % REC_PER_TRK);
          end
        end
      end
    end else if (cyl >= NUM_CYL || rec >= REC_PER_TRK || idx >= BLK_PER_CYL) begin
      res.status = dbba_pkg::ST_BAD_ADDRESS;
    end else if (!used_rows[cyl][idx]) begin
      res.status = dbba_pkg::ST_NOT_ALLOCATED;
    end else begin
      used_rows[cyl][idx] = 1'b0;
      res.status = dbba_pkg::ST_FREED;
    end
    return res;
  endfunction

  function automatic int blocks_in_use();
    int n;
    n = 0;
    for (int c = 0; c < NUM_CYL; c++) n += $countones(used_rows[c]);
    return n;
  endfunction

  task automatic send_request(input logic f, input logic [2:0] cyl, input logic trk,
                              input logic [1:0] rec);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    req_cyl <= cyl;
    req_trk <= trk;
    req_rec <= rec;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    pending_outcomes.push_back(predict_outcome(f, cyl, trk, rec));
    request_count++;
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t exp;
    if (rst_n && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      if (status_o < 5) status_seen[status_o]++;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 status_o);
        error_count++;
      end else begin
        exp = pending_outcomes.pop_front();
        check_field("status", exp.status, status_o);
        check_field("got_cylinder", exp.cyl, got_cyl_o);
        check_field("got_track", exp.trk, got_trk_o);
        check_field("got_record", exp.rec, got_rec_o);
      end
    end
  end

  task automatic test_empty_map();
    send_request(dbba_pkg::FUNC_FREE, 3'd0, 1'b0, 2'd0);
    send_request(dbba_pkg::FUNC_FREE, 3'd7, 1'b1, 2'd3);
    send_request(dbba_pkg::FUNC_FREE, 3'd5, 1'b0, 2'd2);
    send_request(dbba_pkg::FUNC_FREE, 3'd2, 1'b1, 2'd1);
    send_request(dbba_pkg::FUNC_ALLOC, 3'd7, 1'b1, 2'd3);
  endtask

  task automatic test_alloc_free();
    repeat (3) send_request(dbba_pkg::FUNC_ALLOC, 3'd0, 1'b0, 2'd0);
    send_request(dbba_pkg::FUNC_FREE, 3'd0, 1'b0, 2'd1);
    send_request(dbba_pkg::FUNC_FREE, 3'd0, 1'b0, 2'd1);
    send_request(dbba_pkg::FUNC_ALLOC, 3'd0, 1'b0, 2'd0);
    repeat (5) send_request(dbba_pkg::FUNC_ALLOC, 3'd0, 1'b0, 2'd0);
    send_request(dbba_pkg::FUNC_FREE, 3'd1, 1'b0, 2'd0);
    send_request(dbba_pkg::FUNC_FREE, 3'd0, 1'b1, 2'd3);
    send_request(dbba_pkg::FUNC_FREE, 3'd0, 1'b1, 2'd3);
    send_request(dbba_pkg::FUNC_ALLOC, 3'd0, 1'b0, 2'd0);
    send_request(dbba_pkg::FUNC_ALLOC, 3'd0, 1'b0, 2'd0);
  endtask

  // Alternates between filling the disk past full and draining it to empty,
  // so the first-fit search sees every level of occupancy.
  task automatic test_random(input int n_items);
    bit filling;
    int full_tries;
    int pick;
    int in_use [$];
    logic f;
    logic [2:0] cyl;
    logic trk;
    logic [1:0] rec;
    filling = 1'b1;
    full_tries = 0;
    for (int i = 0; i < n_items; i++) begin
      cyl = 3'($urandom);
      trk = 1'($urandom);
      rec = 2'($urandom);
      f = ($urandom_range(0, 99) < (filling ? 15 : 80)) ? dbba_pkg::FUNC_FREE
                                                        : dbba_pkg::FUNC_ALLOC;
      if (f == dbba_pkg::FUNC_FREE && $urandom_range(0, 99) < 85) begin
        in_use.delete();
        for (int k = 0; k < NUM_CYL * BLK_PER_CYL; k++)
          if (used_rows[k / BLK_PER_CYL][k % BLK_PER_CYL]) in_use.push_back(k);
        if (in_use.size() > 0) begin
          pick = in_use[$urandom_range(0, in_use.size() - 1)];
          cyl = 3'(pick / BLK_PER_CYL);
          trk = 1'((pick % BLK_PER_CYL) / REC_PER_TRK);
          rec = 2'((pick % BLK_PER_CYL) % REC_PER_TRK);
        end
      end
      if (f == dbba_pkg::FUNC_ALLOC && blocks_in_use() == NUM_CYL * BLK_PER_CYL) begin
        full_tries++;
      end
      send_request(f, cyl, trk, rec);
      if (filling && full_tries >= 3) begin
        filling = 1'b0;
        full_tries = 0;
      end else if (!filling && blocks_in_use() == 0) begin
        filling = 1'b1;
      end
    end
  endtask

  initial begin
    for (int c = 0; c < NUM_CYL; c++) used_rows[c] = '0;
    for (int s = 0; s < 5; s++) status_seen[s] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 69;
    test_empty_map();
    test_alloc_free();
    test_random(280);

    send_idle_pct = 69;
    recv_idle_pct = 14;
    test_random(285);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(285);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d requests over three idling patterns.", request_count);
    $display("Results: %0d allocated, %0d freed, %0d disk full, %0d not allocated.",
             status_seen[dbba_pkg::ST_ALLOCATED], status_seen[dbba_pkg::ST_FREED],
             status_seen[dbba_pkg::ST_FULL], status_seen[dbba_pkg::ST_NOT_ALLOCATED]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### disk_block_bitmap_allocator.f
+incdir+rtl
rtl/dbba_pkg.sv
rtl/disk_block_bitmap_allocator.sv
test/tb_disk_block_bitmap_allocator.sv
